// ----- design/hlc_pkg.sv -----
// ----------------------------------------------------------------------------
// hlc_pkg
// Shared types, constants and helper functions of the homogeneous line
// clipper: item and lane records, plane setup and output saturation.
// ----------------------------------------------------------------------------
package hlc_pkg;

    // Number of quotient bits produced by the divider chain.
    localparam int DIV_STEPS = 18;
    // Six clip planes, one division lane each.
    localparam int NUM_LANES = 6;
    // Cycles from the accepting edge to the edge at which the result is taken.
    localparam int LATENCY   = 3 + DIV_STEPS + NUM_LANES;

    localparam logic [16:0] Q_ONE      = 17'h10000;
    localparam logic [17:0] R_LIMIT    = 18'h20000;
    localparam logic [15:0] EPS_RESET  = 16'd7;

    // Original start point and endpoint deltas, carried down the chain.
    typedef struct packed {
        logic [3:0][31:0] s;
        logic [3:0][32:0] d;
    } t_item;

    // One plane test in flight through the divider.
    typedef struct packed {
        logic        neg;
        logic        den_neg;
        logic        skip;
        logic        kill;
        logic        sat;
        logic [48:0] rem;
        logic [33:0] dmag;
        logic [17:0] quo;
    } t_lane;

    typedef t_lane [NUM_LANES-1:0] t_lane_row;

    // Running parametric window.
    typedef struct packed {
        logic        ok;
        logic [16:0] t_in;
        logic [16:0] t_out;
    } t_clip;

    // Builds the lane record for one plane from its numerator and denominator.
    function automatic t_lane make_lane(logic [32:0] num, logic [33:0] den,
                                        logic [15:0] eps);
        t_lane       l;
        logic [32:0] nmag;
        logic [33:0] dmag;
        logic [33:0] nsum;
        l    = '0;
        nmag = num[32] ? (~num + 33'd1) : num;
        dmag = den[33] ? (~den + 34'd1) : den;
        nsum = {num[32], num} + {18'd0, eps};
        l.neg     = num[32] ^ den[33];
        l.den_neg = den[33];
        l.skip    = (dmag < {18'd0, eps}) || (den == '0);
        l.kill    = l.skip && nsum[33];
        l.sat     = ({3'd0, nmag} >= {dmag, 2'b00});
        l.rem     = {nmag, 16'd0};
        l.dmag    = dmag;
        l.quo     = '0;
        return l;
    endfunction

    // Saturates a 36-bit signed sum to the signed 32-bit range.
    function automatic logic [31:0] sat32(logic [35:0] v);
        logic [31:0] res;
        if (!v[35] && (v[34:31] != 4'd0)) begin
            res = 32'h7FFF_FFFF;
        end else if (v[35] && (v[34:31] != 4'hF)) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ----- design/hlc_div_cell.sv -----
// ----------------------------------------------------------------------------
// hlc_div_cell
// One restoring division step for all six plane lanes. Each cell settles
// one quotient bit and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module hlc_div_cell
    import hlc_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_item     i_item,
    input  t_lane_row i_lanes,
    output logic      o_valid,
    output t_item     o_item,
    output t_lane_row o_lanes
);

    logic      r_valid;
    t_item     r_item;
    t_lane_row r_lanes;
    t_lane_row n_lanes;

    // Trial subtraction of the shifted divisor in every lane.
    always_comb begin
        logic [51:0] diff;
        n_lanes = i_lanes;
        for (int l = 0; l < NUM_LANES; l++) begin
            diff = {3'd0, i_lanes[l].rem} - ({18'd0, i_lanes[l].dmag} << STEP);
            if (!diff[51]) begin
                n_lanes[l].rem       = diff[48:0];
                n_lanes[l].quo[STEP] = 1'b1;
            end
        end
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= i_item;
        r_lanes <= n_lanes;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_lanes = r_lanes;

endmodule

// ----- design/hlc_plane_cell.sv -----
// ----------------------------------------------------------------------------
// hlc_plane_cell
// Liang-Barsky test of one clip plane: turns the lane quotient into a
// saturated ratio and narrows the entry and exit parameters.
// ----------------------------------------------------------------------------
module hlc_plane_cell
    import hlc_pkg::*;
#(
    parameter int LANE = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_item     i_item,
    input  t_lane_row i_lanes,
    input  t_clip     i_clip,
    output logic      o_valid,
    output t_item     o_item,
    output t_lane_row o_lanes,
    output t_clip     o_clip
);

    logic      r_valid;
    t_item     r_item;
    t_lane_row r_lanes;
    t_clip     r_clip;
    t_clip     n_clip;

    // Ratio saturation and the window update.
    always_comb begin
        t_lane              ln;
        logic [18:0]        mag;
        logic signed [18:0] r;
        logic signed [18:0] tin;
        logic signed [18:0] tout;
        ln   = i_lanes[LANE];
        mag  = (ln.sat || (ln.quo > R_LIMIT)) ? {1'b0, R_LIMIT} : {1'b0, ln.quo};
        r    = ln.neg ? $signed(~mag + 19'd1) : $signed(mag);
        tin  = $signed({2'b00, i_clip.t_in});
        tout = $signed({2'b00, i_clip.t_out});
        n_clip = i_clip;
        if (i_clip.ok) begin
            if (ln.skip) begin
                n_clip.ok = !ln.kill;
            end else if (ln.den_neg) begin
                if (r > tout) begin
                    n_clip.ok = 1'b0;
                end else if (r > tin) begin
                    n_clip.t_in = r[16:0];
                end
            end else begin
                if (r < tin) begin
                    n_clip.ok = 1'b0;
                end else if (r < tout) begin
                    n_clip.t_out = r[16:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= i_item;
        r_lanes <= i_lanes;
        r_clip  <= n_clip;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_lanes = r_lanes;
    assign o_clip  = r_clip;

    // A surviving line keeps an ordered window inside [0, 1].
    a_window_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_clip.ok |-> r_clip.t_in <= r_clip.t_out)
        else $error("clip window inverted");
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_clip.t_out <= Q_ONE)
        else $error("exit parameter above one");

endmodule

// ----- design/hlc_endpoint.sv -----
// ----------------------------------------------------------------------------
// hlc_endpoint
// Endpoint reconstruction: multiplies the deltas by the final parameters,
// then floors, adds the start point and saturates. Rejected lines read zero.
// ----------------------------------------------------------------------------
module hlc_endpoint
    import hlc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item            i_item,
    input  t_clip            i_clip,
    output logic             o_valid,
    output logic             o_accepted,
    output logic [3:0][31:0] o_start,
    output logic [3:0][31:0] o_end
);

    logic             r_valid_a;
    t_item            r_item_a;
    t_clip            r_clip_a;
    logic [3:0][50:0] r_pin;
    logic [3:0][50:0] r_pout;

    logic             r_valid_b;
    logic             r_accepted;
    logic [3:0][31:0] r_start;
    logic [3:0][31:0] r_end;
    logic [3:0][31:0] n_start;
    logic [3:0][31:0] n_end;

    // Control state of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    // Stage A: exact products of delta and parameter.
    always_ff @(posedge i_clk) begin
        r_item_a <= i_item;
        r_clip_a <= i_clip;
        for (int i = 0; i < 4; i++) begin
            r_pin[i]  <= 51'($signed(i_item.d[i]) * $signed({1'b0, i_clip.t_in}));
            r_pout[i] <= 51'($signed(i_item.d[i]) * $signed({1'b0, i_clip.t_out}));
        end
    end

    // Stage B: floor shift, add start, saturate.
    always_comb begin
        logic [35:0] sum_in;
        logic [35:0] sum_out;
        logic [32:0] plain_end;
        for (int i = 0; i < 4; i++) begin
            sum_in    = {{4{r_item_a.s[i][31]}}, r_item_a.s[i]}
                      + {r_pin[i][50], r_pin[i][50:16]};
            sum_out   = {{4{r_item_a.s[i][31]}}, r_item_a.s[i]}
                      + {r_pout[i][50], r_pout[i][50:16]};
            plain_end = {r_item_a.s[i][31], r_item_a.s[i]} + r_item_a.d[i];
            n_start[i] = (r_clip_a.t_in != '0) ? sat32(sum_in) : r_item_a.s[i];
            n_end[i]   = (r_clip_a.t_out != Q_ONE) ? sat32(sum_out) : plain_end[31:0];
            if (!r_clip_a.ok) begin
                n_start[i] = '0;
                n_end[i]   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted <= r_clip_a.ok;
        r_start    <= n_start;
        r_end      <= n_end;
    end

    assign o_valid    = r_valid_b;
    assign o_accepted = r_accepted;
    assign o_start    = r_start;
    assign o_end      = r_end;

endmodule

// ----- design/homogeneous_line_clipper_unit.sv -----
// ----------------------------------------------------------------------------
// homogeneous_line_clipper_unit
// Liang-Barsky clipping of a homogeneous line segment against the six
// planes -w <= x, y, z <= w, built as a chain of division and plane cells.
// ----------------------------------------------------------------------------
// Pipeline: setup, 18 divider cells, 6 plane cells and 2 endpoint stages;
// the result strobe comes from the last endpoint register. Throughput: one
// line per cycle; busy is low except during reset. Reset clears every valid
// bit and sets clip_epsilon to 7.
// ----------------------------------------------------------------------------
module homogeneous_line_clipper_unit
    import hlc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic [31:0] i_start_x,
    input  logic [31:0] i_start_y,
    input  logic [31:0] i_start_z,
    input  logic [31:0] i_start_w,
    input  logic [31:0] i_end_x,
    input  logic [31:0] i_end_y,
    input  logic [31:0] i_end_z,
    input  logic [31:0] i_end_w,
    output logic        o_valid,
    output logic        o_accepted,
    output logic [31:0] o_clipped_start_x,
    output logic [31:0] o_clipped_start_y,
    output logic [31:0] o_clipped_start_z,
    output logic [31:0] o_clipped_start_w,
    output logic [31:0] o_clipped_end_x,
    output logic [31:0] o_clipped_end_y,
    output logic [31:0] o_clipped_end_z,
    output logic [31:0] o_clipped_end_w
);

    logic [15:0] r_eps;
    logic        accept;

    logic        r_valid0;
    t_item       r_item0;
    t_lane_row   r_lanes0;
    t_item       n_item0;
    t_lane_row   n_lanes0;

    logic      div_valid [0:DIV_STEPS];
    t_item     div_item  [0:DIV_STEPS];
    t_lane_row div_lanes [0:DIV_STEPS];

    logic      pl_valid [0:NUM_LANES];
    t_item     pl_item  [0:NUM_LANES];
    t_lane_row pl_lanes [0:NUM_LANES];
    t_clip     pl_clip  [0:NUM_LANES];

    logic [3:0][31:0] res_start;
    logic [3:0][31:0] res_end;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    // Configuration register: one write per completed APB write with paddr[2] low.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_eps} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_eps <= pwdata[15:0];
        end
    end

    // Setup stage: deltas, plane numerators and denominators, lane flags.
    always_comb begin
        logic [3:0][31:0] s;
        logic [3:0][31:0] e;
        logic [32:0]      num;
        logic [33:0]      den;
        s = {i_start_w, i_start_z, i_start_y, i_start_x};
        e = {i_end_w, i_end_z, i_end_y, i_end_x};
        for (int i = 0; i < 4; i++) begin
            n_item0.s[i] = s[i];
            n_item0.d[i] = {e[i][31], e[i]} - {s[i][31], s[i]};
        end
        for (int c = 0; c < 3; c++) begin
            num = {s[3][31], s[3]} - {s[c][31], s[c]};
            den = {n_item0.d[c][32], n_item0.d[c]} - {n_item0.d[3][32], n_item0.d[3]};
            n_lanes0[2*c] = make_lane(num, den, r_eps);
            num = {s[3][31], s[3]} + {s[c][31], s[c]};
            den = 34'd0 - {n_item0.d[3][32], n_item0.d[3]}
                        - {n_item0.d[c][32], n_item0.d[c]};
            n_lanes0[2*c+1] = make_lane(num, den, r_eps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else begin
            r_valid0 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item0  <= n_item0;
        r_lanes0 <= n_lanes0;
    end

    // Divider chain, most significant quotient bit first.
    assign div_valid[0] = r_valid0;
    assign div_item[0]  = r_item0;
    assign div_lanes[0] = r_lanes0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        hlc_div_cell #(
            .STEP(DIV_STEPS - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(div_valid[k]),
            .i_item (div_item[k]),
            .i_lanes(div_lanes[k]),
            .o_valid(div_valid[k+1]),
            .o_item (div_item[k+1]),
            .o_lanes(div_lanes[k+1])
        );
    end

    // Plane chain in the order x<=w, -w<=x, y<=w, -w<=y, z<=w, -w<=z.
    assign pl_valid[0] = div_valid[DIV_STEPS];
    assign pl_item[0]  = div_item[DIV_STEPS];
    assign pl_lanes[0] = div_lanes[DIV_STEPS];
    assign pl_clip[0]  = '{ok: 1'b1, t_in: '0, t_out: Q_ONE};

    for (genvar p = 0; p < NUM_LANES; p++) begin : g_plane
        hlc_plane_cell #(
            .LANE(p)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(pl_valid[p]),
            .i_item (pl_item[p]),
            .i_lanes(pl_lanes[p]),
            .i_clip (pl_clip[p]),
            .o_valid(pl_valid[p+1]),
            .o_item (pl_item[p+1]),
            .o_lanes(pl_lanes[p+1]),
            .o_clip (pl_clip[p+1])
        );
    end

    // Endpoint reconstruction and result register.
    hlc_endpoint u_endpoint (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (pl_valid[NUM_LANES]),
        .i_item    (pl_item[NUM_LANES]),
        .i_clip    (pl_clip[NUM_LANES]),
        .o_valid   (o_valid),
        .o_accepted(o_accepted),
        .o_start   (res_start),
        .o_end     (res_end)
    );

    assign o_clipped_start_x = res_start[0];
    assign o_clipped_start_y = res_start[1];
    assign o_clipped_start_z = res_start[2];
    assign o_clipped_start_w = res_start[3];
    assign o_clipped_end_x   = res_end[0];
    assign o_clipped_end_y   = res_end[1];
    assign o_clipped_end_z   = res_end[2];
    assign o_clipped_end_w   = res_end[3];

    // Every accepted transaction produces exactly one strobe after the latency.
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("result strobe missing");
    a_strobe_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result strobe without a transaction");
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> (res_start == '0) && (res_end == '0))
        else $error("rejected line with nonzero endpoints");

endmodule

// ----- test/homogeneous_line_clipper_unit_tb.sv -----
// ----------------------------------------------------------------------------
// homogeneous_line_clipper_unit_tb
// Self-checking bench for the line clipper: drives segments through the
// command port, predicts each clip result and compares it with the strobed
// output, while the tolerance register is changed between phases.
// ----------------------------------------------------------------------------
module homogeneous_line_clipper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hlc_pkg::*;

    localparam logic [2:0] ADDR_CLIP_EPSILON = 3'd0;
    localparam int         WATCHDOG_LIMIT    = 20000;

    typedef struct packed {
        logic [3:0][31:0] s;
        logic [3:0][31:0] e;
    } t_segment;

    typedef struct packed {
        logic             acc;
        logic [3:0][31:0] cs;
        logic [3:0][31:0] ce;
    } t_clip_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic [3:0][31:0] seg_s = '0;
    logic [3:0][31:0] seg_e = '0;
    logic        o_valid;
    logic        o_accepted;
    logic [3:0][31:0] out_s;
    logic [3:0][31:0] out_e;

    // Model copy of the tolerance register.
    logic [15:0]  model_eps;
    t_clip_result pending_clips[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           send_idle_pct = 0;

    always #5 i_clk = ~i_clk;

    homogeneous_line_clipper_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_start_x(seg_s[0]), .i_start_y(seg_s[1]), .i_start_z(seg_s[2]),
        .i_start_w(seg_s[3]), .i_end_x(seg_e[0]), .i_end_y(seg_e[1]),
        .i_end_z(seg_e[2]), .i_end_w(seg_e[3]),
        .o_valid(o_valid), .o_accepted(o_accepted),
        .o_clipped_start_x(out_s[0]), .o_clipped_start_y(out_s[1]),
        .o_clipped_start_z(out_s[2]), .o_clipped_start_w(out_s[3]),
        .o_clipped_end_x(out_e[0]), .o_clipped_end_y(out_e[1]),
        .o_clipped_end_z(out_e[2]), .o_clipped_end_w(out_e[3])
    );

    // Floor of v / 65536 and saturation to 32 bits.
    function automatic longint floor_q16(longint v);
        return v >>> 16;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // One parametric plane test; returns 0 when the line is rejected.
    function automatic bit test_plane(longint num, longint den, longint eps,
                                      inout longint t_in, inout longint t_out);
        longint mag;
        longint ratio;
        mag = (den < 0) ? -den : den;
        if (mag < eps || den == 0) return !(num < -eps);
        ratio = (num * 65536) / den;
        if (ratio > 131072) ratio = 131072;
        if (ratio < -131072) ratio = -131072;
        if (den < 0) begin
            if (ratio > t_out) return 0;
            if (ratio > t_in) t_in = ratio;
        end else begin
            if (ratio < t_in) return 0;
            if (ratio < t_out) t_out = ratio;
        end
        return 1;
    endfunction

    // Computes the clipped segment for one input line.
    function automatic t_clip_result clip_segment(t_segment seg, logic [15:0] eps_reg);
        t_clip_result res;
        longint s[4];
        longint d[4];
        longint t_in;
        longint t_out;
        longint eps;
        bit     ok;
        res = '0;
        t_in = 0;
        t_out = 65536;
        eps = eps_reg;
        ok = 1;
        for (int i = 0; i < 4; i++) begin
            s[i] = longint'($signed(seg.s[i]));
            d[i] = longint'($signed(seg.e[i])) - s[i];
        end
        for (int c = 0; c < 3; c++) begin
            if (ok) ok = test_plane(s[3] - s[c], -d[3] + d[c], eps, t_in, t_out);
            if (ok) ok = test_plane(s[3] + s[c], -d[3] - d[c], eps, t_in, t_out);
        end
        if (!ok) return res;
        res.acc = 1'b1;
        for (int i = 0; i < 4; i++) begin
            res.cs[i] = seg.s[i];
            res.ce[i] = seg.e[i];
            if (t_out < 65536) res.ce[i] = clamp32(s[i] + floor_q16(d[i] * t_out));
            if (t_in > 0) res.cs[i] = clamp32(s[i] + floor_q16(d[i] * t_in));
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Result checker and watchdog, both on the rising edge.
    always @(posedge i_clk) begin
        t_clip_result want;
        if (i_rst_n && ((start && !busy) || o_valid)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_clips.size() == 0) begin
                report_mismatch("unexpected transaction", 32'd0, 32'd0);
            end else begin
                want = pending_clips.pop_front();
                if (o_accepted !== want.acc)
                    report_mismatch("accepted", {31'd0, o_accepted}, {31'd0, want.acc});
                for (int i = 0; i < 4; i++) begin
                    if (out_s[i] !== want.cs[i])
                        report_mismatch($sformatf("clipped_start[%0d]", i), out_s[i],
                                        want.cs[i]);
                    if (out_e[i] !== want.ce[i])
                        report_mismatch($sformatf("clipped_end[%0d]", i), out_e[i],
                                        want.ce[i]);
                end
            end
        end
    end

    // Sends one line and records its expected clip result. Start stays high
    // into the next send so lines can follow back to back.
    task automatic send_segment(t_segment seg);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        seg_s <= seg.s;
        seg_e <= seg.e;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_clips.push_back(clip_segment(seg, model_eps));
        @(negedge i_clk);
    endtask

    // Waits for every expected transaction, then lets the pipeline drain.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_clips.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_epsilon(logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_CLIP_EPSILON;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_eps = value[15:0];
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7FFF_FFFF - $urandom_range(3);
            default: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
        endcase
    endfunction

    // Mostly lines near the view volume with positive w, some raw noise.
    function automatic t_segment rand_segment();
        t_segment seg;
        for (int i = 0; i < 4; i++) begin
            seg.s[i] = rand_coord();
            seg.e[i] = rand_coord();
        end
        if ($urandom_range(3) != 0) begin
            seg.s[3] = $urandom_range(3 * 65536);
            seg.e[3] = $urandom_range(3 * 65536);
        end
        if ($urandom_range(9) == 0) seg.e = seg.s;
        else if ($urandom_range(9) == 0) seg.e[3] = seg.s[3] + $urandom_range(15);
        return seg;
    endfunction

    function automatic t_segment make_segment(int sx, int sy, int sz, int sw,
                                              int ex, int ey, int ez, int ew);
        t_segment seg;
        seg.s = {sw, sz, sy, sx};
        seg.e = {ew, ez, ey, ex};
        return seg;
    endfunction

    task automatic test_directed();
        localparam int ONE = 65536;
        send_segment(make_segment(0, 0, 0, ONE, ONE / 2, 0, 0, ONE));
        send_segment(make_segment(-2 * ONE, 0, 0, ONE, 2 * ONE, 0, 0, ONE));
        send_segment(make_segment(0, -2 * ONE, 0, ONE, 0, 2 * ONE, 0, ONE));
        send_segment(make_segment(0, 0, -2 * ONE, ONE, 0, 0, 2 * ONE, ONE));
        send_segment(make_segment(2 * ONE, 0, 0, ONE, 3 * ONE, 0, 0, ONE));
        send_segment(make_segment(ONE / 2, 0, 0, ONE, ONE / 2, 0, 0, ONE));
        send_segment(make_segment(2 * ONE, 0, 0, ONE, 2 * ONE, 5, 0, ONE + 3));
        send_segment(make_segment(0, 0, 0, 0, 0, 0, 0, 0));
        send_segment(make_segment(-1000 * ONE, 0, 0, ONE, 1000 * ONE, 3, 0, ONE));
        send_segment(make_segment(-100, 0, 0, 1, 30000, 0, 0, 1));
        send_segment({{4{32'h7FFF_FFFF}}, {4{32'h8000_0000}}});
        send_segment({{4{32'h8000_0000}}, {4{32'h7FFF_FFFF}}});
        send_segment({{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000},
                      {32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF}});
        send_segment({{4{32'hFFFF_FFFF}}, {4{32'h0}}});
        send_segment({{4{32'h5555_5555}}, {4{32'hAAAA_AAAA}}});
        wait_idle();
    endtask

    task automatic test_random(int count, int idle_pct);
        send_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) send_segment(rand_segment());
        wait_idle();
        send_idle_pct = 0;
    endtask

    task automatic test_epsilon_settings();
        write_epsilon(32'h0);
        test_random(120, 0);
        write_epsilon(32'hFFFF_FFFF);
        test_random(120, 59);
        write_epsilon(32'h0000_0100);
        test_random(120, 21);
        write_epsilon(32'h0000_0007);
    endtask

    initial begin
        model_eps = EPS_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(220, 0);
        test_random(200, 59);
        test_epsilon_settings();
        wait_idle();
        if (error_count == 0 && pending_clips.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
